// ===== hw/rtl/scc_pkg.sv =====
`default_nettype none
package scc_pkg;

  localparam int SAMPLE_W   = 24;
  localparam int ENV_W      = 25;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int CNT_W      = 5;

  localparam int SQRT_STEPS = 25;
  localparam int LOG_STEPS  = 16;
  localparam int HORN_TERMS = 9;

  localparam logic [30:0] ONE_Q30        = 31'h4000_0000;
  localparam logic [18:0] DB_PER_OCT_Q16 = 19'd394566;
  localparam logic [21:0] OCT_PER_DB_Q24 = 22'd2786635;
  localparam logic [29:0] LN2_Q30        = 30'd744261118;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THRESHOLD = 3'd0,
    REG_SLOPE     = 3'd1,
    REG_ATTACK    = 3'd2,
    REG_RELEASE   = 3'd3,
    REG_MAKEUP    = 3'd4,
    REG_LINK      = 3'd5,
    REG_ACTIVE    = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [15:0] threshold_q8;
    logic [20:0] compression_slope;
    logic [23:0] attack_coeff;
    logic [23:0] release_coeff;
    logic [23:0] makeup_gain;
    logic        link_channels;
    logic [1:0]  active_channels;
  } cfg_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_SQ_A,
    OP_SQ_B,
    OP_SQRT_STEP,
    OP_LEVEL,
    OP_SM0_MUL,
    OP_SM0_FIN,
    OP_SM1_MUL,
    OP_SM1_FIN,
    OP_SELECT,
    OP_NORM,
    OP_LOG_STEP,
    OP_DB_MUL,
    OP_DB_FIN,
    OP_GR_MUL,
    OP_GR_FIN,
    OP_X_MUL,
    OP_Y_MUL,
    OP_Y_FIN,
    OP_HORN_MUL,
    OP_HORN_DIV,
    OP_GAIN,
    OP_OUT_L,
    OP_OUT_R,
    OP_PUBLISH
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [3:0] k;
  } dp_cmd_t;

  typedef struct packed {
    logic unlinked2;
    logic norm_done;
    logic out_free;
  } dp_status_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_SQ_A,
    S_SQ_B,
    S_SQRT,
    S_LEVEL,
    S_SM0_MUL,
    S_SM0_FIN,
    S_SM1_MUL,
    S_SM1_FIN,
    S_SELECT,
    S_NORM,
    S_LOG,
    S_DB_MUL,
    S_DB_FIN,
    S_GR_MUL,
    S_GR_FIN,
    S_X_MUL,
    S_Y_MUL,
    S_Y_FIN,
    S_HORN_MUL,
    S_HORN_DIV,
    S_GAIN,
    S_OUT_L,
    S_OUT_R,
    S_PUBLISH
  } ctrl_state_t;

  // ceil(2^34 / k) for k from 2 to 9, else zero; exact floor division for 30-bit dividends
  function automatic logic [33:0] recip_q34(input logic [3:0] k);
    logic [33:0] r;
    unique case (k)
      4'd2:    r = 34'd8589934592;
      4'd3:    r = 34'd5726623062;
      4'd4:    r = 34'd4294967296;
      4'd5:    r = 34'd3435973837;
      4'd6:    r = 34'd2863311531;
      4'd7:    r = 34'd2454267027;
      4'd8:    r = 34'd2147483648;
      4'd9:    r = 34'd1908874354;
      default: r = 34'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/scc_cfg.sv =====
`default_nettype none
module scc_cfg
  import scc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                       cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.threshold_q8      <= 16'hEC00;
      cfg.compression_slope <= 21'd49152;
      cfg.attack_coeff      <= 24'd16000000;
      cfg.release_coeff     <= 24'd16700000;
      cfg.makeup_gain       <= 24'd65536;
      cfg.link_channels     <= 1'b1;
      cfg.active_channels   <= 2'd2;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_THRESHOLD: cfg.threshold_q8      <= cfg_data[15:0];
        REG_SLOPE:     cfg.compression_slope <= cfg_data[20:0];
        REG_ATTACK:    cfg.attack_coeff      <= cfg_data;
        REG_RELEASE:   cfg.release_coeff     <= cfg_data;
        REG_MAKEUP:    cfg.makeup_gain       <= cfg_data;
        REG_LINK:      cfg.link_channels     <= cfg_data[0];
        REG_ACTIVE:    cfg.active_channels   <= cfg_data[1:0];
        default: begin
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/scc_ctrl.sv =====
`default_nettype none
module scc_ctrl
  import scc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire dp_status_t st,
  output dp_cmd_t         cmd
);

  ctrl_state_t      state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd.op     = OP_NONE;
    cmd.k      = cnt[3:0];
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = OP_LOAD;
          state_next = S_SQ_A;
        end
      end
      S_SQ_A: begin
        cmd.op     = OP_SQ_A;
        state_next = S_SQ_B;
      end
      S_SQ_B: begin
        cmd.op     = OP_SQ_B;
        cnt_next   = '0;
        state_next = S_SQRT;
      end
      S_SQRT: begin
        cmd.op = OP_SQRT_STEP;
        if (cnt == CNT_W'(SQRT_STEPS - 1)) begin
          state_next = S_LEVEL;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_LEVEL: begin
        cmd.op     = OP_LEVEL;
        state_next = S_SM0_MUL;
      end
      S_SM0_MUL: begin
        cmd.op     = OP_SM0_MUL;
        state_next = S_SM0_FIN;
      end
      S_SM0_FIN: begin
        cmd.op     = OP_SM0_FIN;
        state_next = st.unlinked2 ? S_SM1_MUL : S_SELECT;
      end
      S_SM1_MUL: begin
        cmd.op     = OP_SM1_MUL;
        state_next = S_SM1_FIN;
      end
      S_SM1_FIN: begin
        cmd.op     = OP_SM1_FIN;
        state_next = S_SELECT;
      end
      S_SELECT: begin
        cmd.op     = OP_SELECT;
        state_next = S_NORM;
      end
      S_NORM: begin
        if (st.norm_done) begin
          cnt_next   = '0;
          state_next = S_LOG;
        end else begin
          cmd.op = OP_NORM;
        end
      end
      S_LOG: begin
        cmd.op = OP_LOG_STEP;
        if (cnt == CNT_W'(LOG_STEPS - 1)) begin
          state_next = S_DB_MUL;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_DB_MUL: begin
        cmd.op     = OP_DB_MUL;
        state_next = S_DB_FIN;
      end
      S_DB_FIN: begin
        cmd.op     = OP_DB_FIN;
        state_next = S_GR_MUL;
      end
      S_GR_MUL: begin
        cmd.op     = OP_GR_MUL;
        state_next = S_GR_FIN;
      end
      S_GR_FIN: begin
        cmd.op     = OP_GR_FIN;
        state_next = S_X_MUL;
      end
      S_X_MUL: begin
        cmd.op     = OP_X_MUL;
        state_next = S_Y_MUL;
      end
      S_Y_MUL: begin
        cmd.op     = OP_Y_MUL;
        state_next = S_Y_FIN;
      end
      S_Y_FIN: begin
        cmd.op     = OP_Y_FIN;
        cnt_next   = CNT_W'(HORN_TERMS);
        state_next = S_HORN_MUL;
      end
      S_HORN_MUL: begin
        cmd.op     = OP_HORN_MUL;
        state_next = S_HORN_DIV;
      end
      S_HORN_DIV: begin
        cmd.op = OP_HORN_DIV;
        if (cnt == CNT_W'(1)) begin
          state_next = S_GAIN;
        end else begin
          cnt_next   = cnt - 1'b1;
          state_next = S_HORN_MUL;
        end
      end
      S_GAIN: begin
        cmd.op     = OP_GAIN;
        state_next = S_OUT_L;
      end
      S_OUT_L: begin
        cmd.op     = OP_OUT_L;
        state_next = S_OUT_R;
      end
      S_OUT_R: begin
        cmd.op     = OP_OUT_R;
        state_next = S_PUBLISH;
      end
      S_PUBLISH: begin
        if (st.out_free) begin
          cmd.op     = OP_PUBLISH;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == S_SQ_A))
    else $error("request accepted without starting the sequence");
  a_horn_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_HORN_DIV) |-> (cnt >= CNT_W'(1) && cnt <= CNT_W'(HORN_TERMS)))
    else $error("series term index out of range");
  a_publish_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_PUBLISH) |=> (state == S_IDLE))
    else $error("publish did not return to idle");
`endif

endmodule
`default_nettype wire

// ===== hw/rtl/scc_dp.sv =====
`default_nettype none
module scc_dp
  import scc_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire cfg_t                cfg,
  input  wire dp_cmd_t             cmd,
  output dp_status_t               st,
  input  wire logic [SAMPLE_W-1:0] side_left,
  input  wire logic [SAMPLE_W-1:0] side_right,
  input  wire logic [SAMPLE_W-1:0] main_left,
  input  wire logic [SAMPLE_W-1:0] main_right,
  output logic [SAMPLE_W-1:0]      out_left,
  output logic [SAMPLE_W-1:0]      out_right,
  output logic [14:0]              reduction_db,
  output logic                     out_valid,
  input  wire logic                out_stall
);

  function automatic logic [23:0] mag24(input logic [23:0] s);
    return s[23] ? (~s + 24'd1) : s;
  endfunction

  function automatic logic [23:0] sat_out(input logic [56:0] prod, input logic neg);
    logic [57:0] rnd;
    logic [33:0] m;
    logic [23:0] r;
    rnd = {1'b0, prod} + 58'h80_0000;
    m   = rnd[57:24];
    if (neg) begin
      r = (m > 34'h80_0000) ? 24'h80_0000 : (~m[23:0] + 24'd1);
    end else begin
      r = (m > 34'h7F_FFFF) ? 24'h7F_FFFF : m[23:0];
    end
    return r;
  endfunction

  logic [23:0] sl_mag, sr_mag, ml, mr;
  logic        n2;
  logic [47:0] sq;
  logic [49:0] rad;
  logic [24:0] root;
  logic [26:0] rem;
  logic [24:0] level0, level1, env0, env1;
  logic [47:0] sm_prod;
  logic        sm_up;
  logic [30:0] m;
  logic [4:0]  sh;
  logic [15:0] frac;
  logic        env_zero;
  logic [39:0] db_prod;
  logic [17:0] edb;
  logic [36:0] gr_prod;
  logic        reduce_on;
  logic [14:0] gr;
  logic [36:0] x_prod;
  logic [4:0]  whole;
  logic [45:0] y_prod;
  logic [29:0] y;
  logic [30:0] p;
  logic [29:0] t;
  logic [54:0] g_prod;
  logic [56:0] o_prod;
  logic [23:0] res_l;

  logic [47:0] sq_l, sq_r;
  logic [28:0] rem_t, trial;
  logic        sm_sel;
  logic [24:0] sm_env, sm_lv, sm_diff, sm_rnd, sm_new;
  logic [23:0] sm_coeff;
  logic [48:0] sm_rsum;
  logic [24:0] esel;
  logic [61:0] lsq;
  logic [31:0] mm;
  logic [20:0] neg_oct;
  logic [40:0] db_rsum;
  logic [17:0] thr_ext, dlt;
  logic        slope_pos;
  logic [37:0] gr_rsum;
  logic [21:0] gr_t;
  logic [37:0] x_rsum;
  logic [20:0] x_val;
  logic [60:0] hp;
  logic [63:0] qp;
  logic [29:0] q;
  logic [30:0] ps;
  logic [32:0] gain;

  always_comb begin
    sq_l    = sl_mag * sl_mag;
    sq_r    = sr_mag * sr_mag;
    rem_t   = {rem, rad[49:48]};
    trial   = {2'b00, root, 2'b01};
    sm_sel  = (cmd.op == OP_SM1_MUL) || (cmd.op == OP_SM1_FIN);
    sm_env  = sm_sel ? env1 : env0;
    sm_lv   = sm_sel ? level1 : level0;
    sm_coeff = (sm_lv > sm_env) ? cfg.attack_coeff : cfg.release_coeff;
    sm_diff = (sm_lv > sm_env) ? (sm_lv - sm_env) : (sm_env - sm_lv);
    sm_rsum = {1'b0, sm_prod} + 49'h80_0000;
    sm_rnd  = sm_rsum[48:24];
    sm_new  = sm_up ? (sm_lv - sm_rnd) : (sm_lv + sm_rnd);
    esel    = (n2 && !cfg.link_channels && (env1 > env0)) ? env1 : env0;
    lsq     = m * m;
    mm      = lsq[61:30];
    neg_oct = {sh - 5'd6, 16'd0} - {5'd0, frac};
    db_rsum = {1'b0, db_prod} + 41'h80_0000;
    thr_ext = {{2{cfg.threshold_q8[15]}}, cfg.threshold_q8};
    dlt     = edb - thr_ext;
    slope_pos = !cfg.compression_slope[20] && (cfg.compression_slope != 21'd0);
    gr_rsum = {1'b0, gr_prod} + 38'h8000;
    gr_t    = gr_rsum[37:16];
    x_rsum  = {1'b0, x_prod} + 38'h8000;
    x_val   = x_rsum[36:16];
    hp      = y * p;
    qp      = t * recip_q34(cmd.k);
    q       = (cmd.k == 4'd1) ? t : qp[63:34];
    ps      = (whole == 5'd31) ? 31'd0 : (p >> whole);
    gain    = g_prod[54:22];
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD: begin
        sl_mag <= mag24(side_left);
        sr_mag <= mag24(side_right);
        ml     <= main_left;
        mr     <= main_right;
        n2     <= cfg.active_channels[1];
      end
      OP_SQ_A: begin
        sq   <= sq_l;
        root <= '0;
        rem  <= '0;
      end
      OP_SQ_B: begin
        rad <= {1'b0, sq + sq_r, 1'b0};
      end
      OP_SQRT_STEP: begin
        rad <= {rad[47:0], 2'b00};
        if (rem_t >= trial) begin
          rem  <= 27'(rem_t - trial);
          root <= {root[23:0], 1'b1};
        end else begin
          rem  <= rem_t[26:0];
          root <= {root[23:0], 1'b0};
        end
      end
      OP_LEVEL: begin
        level0 <= n2 ? root : {sl_mag, 1'b0};
        level1 <= {sr_mag, 1'b0};
      end
      OP_SM0_MUL, OP_SM1_MUL: begin
        sm_prod <= sm_coeff * sm_diff;
        sm_up   <= sm_lv > sm_env;
      end
      OP_SELECT: begin
        m        <= {6'd0, esel};
        sh       <= '0;
        frac     <= '0;
        env_zero <= (esel == 25'd0);
      end
      OP_NORM: begin
        priority if (m[30:23] == 8'd0) begin
          m  <= {m[22:0], 8'd0};
          sh <= sh + 5'd8;
        end else if (m[30:27] == 4'd0) begin
          m  <= {m[26:0], 4'd0};
          sh <= sh + 5'd4;
        end else if (m[30:29] == 2'd0) begin
          m  <= {m[28:0], 2'd0};
          sh <= sh + 5'd2;
        end else begin
          m  <= {m[29:0], 1'b0};
          sh <= sh + 5'd1;
        end
      end
      OP_LOG_STEP: begin
        m    <= mm[31] ? mm[31:1] : mm[30:0];
        frac <= {frac[14:0], mm[31]};
      end
      OP_DB_MUL: begin
        db_prod <= neg_oct * DB_PER_OCT_Q16;
      end
      OP_DB_FIN: begin
        edb <= 18'd0 - {1'b0, db_rsum[40:24]};
      end
      OP_GR_MUL: begin
        gr_prod   <= dlt[16:0] * cfg.compression_slope[19:0];
        reduce_on <= !env_zero && slope_pos && !dlt[17] && (dlt != 18'd0);
      end
      OP_GR_FIN: begin
        if (!reduce_on) begin
          gr <= '0;
        end else begin
          gr <= (gr_t > 22'd32767) ? 15'h7FFF : gr_t[14:0];
        end
      end
      OP_X_MUL: begin
        x_prod <= gr * OCT_PER_DB_Q24;
      end
      OP_Y_MUL: begin
        whole  <= x_val[20:16];
        y_prod <= x_val[15:0] * LN2_Q30;
      end
      OP_Y_FIN: begin
        y <= y_prod[45:16];
        p <= ONE_Q30;
      end
      OP_HORN_MUL: begin
        t <= hp[59:30];
      end
      OP_HORN_DIV: begin
        p <= ONE_Q30 - {1'b0, q};
      end
      OP_GAIN: begin
        g_prod <= ps * cfg.makeup_gain;
      end
      OP_OUT_L: begin
        o_prod <= mag24(ml) * gain;
      end
      OP_OUT_R: begin
        res_l  <= sat_out(o_prod, ml[23]);
        o_prod <= mag24(mr) * gain;
      end
      OP_PUBLISH: begin
        out_left     <= res_l;
        out_right    <= n2 ? sat_out(o_prod, mr[23]) : mr;
        reduction_db <= gr;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      env0 <= '0;
    end else if (cmd.op == OP_SM0_FIN) begin
      env0 <= sm_new;
    end
  end

  // env1 is also written on the linked copy in the select step
  always_ff @(posedge clk) begin
    if (rst) begin
      env1 <= '0;
    end else if (cmd.op == OP_SM1_FIN) begin
      env1 <= sm_new;
    end else if (cmd.op == OP_SELECT && n2 && cfg.link_channels) begin
      env1 <= env0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.op == OP_PUBLISH) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  assign st.unlinked2 = n2 && !cfg.link_channels;
  assign st.norm_done = m[30] || (m == 31'd0);
  assign st.out_free  = !out_valid || !out_stall;

`ifndef SYNTHESIS
  a_publish_valid: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_PUBLISH) |=> out_valid)
    else $error("result not presented after publish");
  a_publish_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_PUBLISH) |-> (!out_valid || !out_stall))
    else $error("publish overwrote a pending result");
  a_no_reduction: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_GR_FIN && !reduce_on) |=> (gr == 15'd0))
    else $error("gain reduction without threshold crossing");
`endif

endmodule
`default_nettype wire

// ===== hw/rtl/sidechain_rms_compressor_core.sv =====
// A request is taken only while idle; in_stall then holds off the next
// frame until its result is published. A single sequencer runs the
// 25-step square root, 16 log squarings and the 9-term exp series in turn.
// Reset (rst, synchronous): envelopes cleared, registers to defaults, idle.
`default_nettype none
module sidechain_rms_compressor_core
  import scc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [SAMPLE_W-1:0]   side_left,
  input  wire logic [SAMPLE_W-1:0]   side_right,
  input  wire logic [SAMPLE_W-1:0]   main_left,
  input  wire logic [SAMPLE_W-1:0]   main_right,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [SAMPLE_W-1:0]        out_left,
  output logic [SAMPLE_W-1:0]        out_right,
  output logic [14:0]                reduction_db
);

  cfg_t       cfg;
  dp_cmd_t    cmd;
  dp_status_t st;

  scc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  scc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  scc_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .cmd          (cmd),
    .st           (st),
    .side_left    (side_left),
    .side_right   (side_right),
    .main_left    (main_left),
    .main_right   (main_right),
    .out_left     (out_left),
    .out_right    (out_right),
    .reduction_db (reduction_db),
    .out_valid    (out_valid),
    .out_stall    (out_stall)
  );

endmodule
`default_nettype wire

// ===== bench/tb_sidechain_rms_compressor_core.sv =====
`default_nettype none
module tb_sidechain_rms_compressor_core;
  import scc_pkg::*;

  typedef struct {
    logic [23:0] sl, sr, ml, mr;
    bit          typed;
    logic [23:0] el, er;
    logic [14:0] egr;
  } stim_row_t;

  typedef struct {
    logic [23:0] l, r;
    logic [14:0] gr;
  } frame_out_t;

  logic        clk = 0, rst = 1;
  logic        cfg_valid = 0, cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [23:0] cfg_data = '0;
  logic        in_valid = 0, in_stall;
  logic [23:0] side_left = '0, side_right = '0, main_left = '0, main_right = '0;
  logic        out_valid, out_stall = 0;
  logic [23:0] out_left, out_right;
  logic [14:0] reduction_db;

  sidechain_rms_compressor_core dut (.*);

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  initial begin
    #40_000_000;
    $display("tb_sidechain_rms_compressor_core failed");
    $finish;
  end

  // shadow registers and envelopes
  longint          thr, slope;
  longint unsigned att, rel, makeup, link, active;
  longint unsigned env_q[2];

  frame_out_t pending_frames[$];
  int  mismatches = 0, frames_sent = 0, frames_checked = 0, phases_run = 0;
  bit  quiet = 0;

  function automatic longint unsigned magnitude(longint s);
    return (s < 0) ? longint'(-s) : s;
  endfunction

  function automatic longint unsigned isqrt_floor(longint unsigned v);
    longint unsigned r = 0, b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else r >>= 1;
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint unsigned track_env(longint unsigned e, longint unsigned lvl);
    if (lvl > e) return lvl - ((att * (lvl - e) + (64'd1 << 23)) >> 24);
    return lvl + ((rel * (e - lvl) + (64'd1 << 23)) >> 24);
  endfunction

  function automatic longint level_to_db(longint unsigned e);
    int msb = 0;
    longint unsigned m, frac = 0, neg;
    for (int i = 0; i < 64; i++) if (e[i]) msb = i;
    m = (msb <= 30) ? (e << (30 - msb)) : (e >> (msb - 30));
    for (int i = 0; i < 16; i++) begin
      m = (m * m) >> 30;
      if (m >= (64'd1 << 31)) begin
        m >>= 1;
        frac |= 64'd1 << (15 - i);
      end
    end
    neg = longint'(24 - msb) * 65536 - frac;
    return -longint'((neg * 394566 + (64'd1 << 23)) >> 24);
  endfunction

  function automatic longint unsigned gain_from_reduction(longint unsigned gr);
    longint unsigned x, whole, y, p;
    x = (gr * 2786635 + (64'd1 << 15)) >> 16;
    whole = x >> 16;
    y = ((x & 64'hFFFF) * 744261118) >> 16;
    p = 64'd1 << 30;
    for (int k = 9; k >= 1; k--) p = (64'd1 << 30) - (((y * p) >> 30) / k);
    p = (whole >= 31) ? 0 : (p >> whole);
    return (p * makeup) >> 22;
  endfunction

  function automatic logic [23:0] scale_sample(longint s, longint unsigned g);
    longint unsigned m = (magnitude(s) * g + (64'd1 << 23)) >> 24;
    longint r;
    if (s < 0) r = (m > 64'd8388608) ? -8388608 : -longint'(m);
    else r = (m > 64'd8388607) ? 8388607 : longint'(m);
    return r[23:0];
  endfunction

  function automatic frame_out_t compress_frame(logic [23:0] sl, sr, ml, mr);
    frame_out_t o;
    longint s0 = longint'($signed(sl)), s1 = longint'($signed(sr));
    longint unsigned lvl, e, gr = 0, g, a, b;
    int n = (active < 1) ? 1 : (active > 2) ? 2 : int'(active);
    if (n == 1) lvl = 2 * magnitude(s0);
    else begin
      a = magnitude(s0);
      b = magnitude(s1);
      lvl = isqrt_floor(2 * (a * a + b * b));
    end
    env_q[0] = track_env(env_q[0], lvl);
    if (n == 2) env_q[1] = link ? env_q[0] : track_env(env_q[1], 2 * magnitude(s1));
    e = env_q[0];
    if (!link && n == 2 && env_q[1] > e) e = env_q[1];
    if (e > 0 && slope > 0) begin
      longint edb = level_to_db(e);
      if (edb > thr) begin
        gr = (longint'(edb - thr) * slope + (64'd1 << 15)) >> 16;
        if (gr > 32767) gr = 32767;
      end
    end
    g = gain_from_reduction(gr);
    o.l = scale_sample($signed(ml), g);
    o.r = (n == 2) ? scale_sample($signed(mr), g) : mr;
    o.gr = gr[14:0];
    return o;
  endfunction

  function automatic int gap_len();
    int p = $urandom_range(0, 99);
    if (quiet || p < 65) return 0;
    if (p < 95) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  task automatic write_reg(cfg_reg_t idx, logic [23:0] val);
    @(negedge clk);
    cfg_valid = 1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_THRESHOLD: thr = longint'($signed(val[15:0]));
      REG_SLOPE:     slope = longint'($signed(val[20:0]));
      REG_ATTACK:    att = val;
      REG_RELEASE:   rel = val;
      REG_MAKEUP:    makeup = val;
      REG_LINK:      link = val[0];
      REG_ACTIVE:    active = val[1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 0;
  endtask

  task automatic send_frame(stim_row_t row);
    int gap = gap_len();
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1;
    side_left = row.sl;
    side_right = row.sr;
    main_left = row.ml;
    main_right = row.mr;
    do @(posedge clk); while (in_stall);
    begin
      frame_out_t p = compress_frame(row.sl, row.sr, row.ml, row.mr);
      if (row.typed) begin
        p.l = row.el;
        p.r = row.er;
        p.gr = row.egr;
      end
      pending_frames.insert(pending_frames.size(), p);
    end
    frames_sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 0;
    while (pending_frames.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  function automatic logic [23:0] rand_sample();
    int p = $urandom_range(0, 99);
    logic [23:0] v = 24'($urandom);
    if (p < 4) return 24'h7FFFFF;
    if (p < 8) return 24'h800000;
    if (p < 12) return 24'h0;
    return 24'($signed(v) >>> $urandom_range(0, 22));
  endfunction

  // sends one block; bursts of loud sidechain between quiet stretches
  task automatic random_block(int count);
    stim_row_t row;
    int loud = 0;
    row.typed = 0;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 15) == 0) loud = !loud;
      row.sl = rand_sample();
      row.sr = rand_sample();
      if (!loud) begin
        row.sl = 24'($signed(row.sl) >>> 8);
        row.sr = 24'($signed(row.sr) >>> 8);
      end
      row.ml = rand_sample();
      row.mr = rand_sample();
      send_frame(row);
    end
  endtask

  always @(negedge clk) begin
    int hold;
    if (hold > 0) hold--;
    else if (!quiet && $urandom_range(0, 99) < 30)
      hold = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 80) : $urandom_range(1, 3);
    else hold = 0;
    out_stall = (hold > 0);
  end

  always @(posedge clk) begin
    frame_out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_frames.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected frame out %h %h %h",
                                       out_left, out_right, reduction_db);
      end else begin
        want = pending_frames.pop_front();
        frames_checked++;
        if (want.l !== out_left || want.r !== out_right || want.gr !== reduction_db) begin
          mismatches++;
          if (mismatches <= 10)
            $display("frame %0d: want %h %h %h got %h %h %h", frames_checked,
                     want.l, want.r, want.gr, out_left, out_right, reduction_db);
        end
      end
    end
  end

  stim_row_t directed[$];
  logic [23:0] cfg_plan[7];

  function automatic stim_row_t mk(logic [23:0] sl, sr, ml, mr, bit typed,
                                   logic [23:0] el, er, logic [14:0] egr);
    stim_row_t r;
    r.sl = sl; r.sr = sr; r.ml = ml; r.mr = mr;
    r.typed = typed; r.el = el; r.er = er; r.egr = egr;
    return r;
  endfunction

  function automatic void add_row(stim_row_t r);
    directed.insert(directed.size(), r);
  endfunction

  initial begin
    thr = -5120; slope = 49152; att = 16000000; rel = 16700000;
    makeup = 65536; link = 1; active = 2;
    env_q[0] = 0; env_q[1] = 0;
    // silent sidechain after reset: unity gain, no reduction
    add_row(mk(0, 0, 24'h7FFFFF, 24'h800000, 1, 24'h7FFFFF, 24'h800000, 0));
    add_row(mk(0, 0, 24'h800000, 24'h7FFFFF, 1, 24'h800000, 24'h7FFFFF, 0));
    add_row(mk(0, 0, 24'h000001, 24'hFFFFFF, 1, 24'h000001, 24'hFFFFFF, 0));
    add_row(mk(0, 0, 0, 24'h555555, 1, 0, 24'h555555, 0));
    add_row(mk(24'h7FFFFF, 24'h800000, 24'h400000, 24'hC00000, 0, 0, 0, 0));
    add_row(mk(24'h800000, 24'h800000, 24'h7FFFFF, 24'h800000, 0, 0, 0, 0));
    add_row(mk(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h800000, 0, 0, 0, 0));
    add_row(mk(24'h000001, 0, 24'h123456, 24'hABCDEF, 0, 0, 0, 0));
    add_row(mk(0, 24'hFFFFFF, 24'h7FFFFF, 24'h000001, 0, 0, 0, 0));
    add_row(mk(24'hAAAAAA, 24'h555555, 24'hAAAAAA, 24'h555555, 0, 0, 0, 0));
    for (int i = 0; i < 8; i++)
      add_row(mk(0, 0, 24'h7FFFFF, 24'h800000, 0, 0, 0, 0));

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 0;
    foreach (directed[i]) send_frame(directed[i]);
    drain();

    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: cfg_plan = '{24'h008000, 24'h00FFFF, 24'h0, 24'hFFFFFF, 24'hFFFFFF, 0, 1};
        1: cfg_plan = '{24'h0, 24'h170000, 24'hFFFFFF, 24'h0, 24'h0, 1, 0};
        2: cfg_plan = '{24'hF000, 24'h0, 24'h800000, 24'h800000, 24'h010000, 0, 3};
        3: cfg_plan = '{24'hEC00, 24'h00FFFF, 24'h100000, 24'hFF0000, 24'h040000, 0, 2};
        4: cfg_plan = '{24'h0, 24'h00FFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1, 2};
        default: begin
          cfg_plan[0] = 24'($urandom_range(0, 32768) + 32'h8000);
          cfg_plan[1] = ($urandom_range(0, 3) == 0)
                        ? 24'(32'h1F0000 | $urandom_range(0, 65535))
                        : 24'($urandom_range(0, 65535));
          cfg_plan[2] = 24'($urandom);
          cfg_plan[3] = 24'($urandom);
          cfg_plan[4] = ($urandom_range(0, 3) == 0) ? 24'($urandom)
                                                    : 24'($urandom_range(0, 262143));
          cfg_plan[5] = 24'($urandom_range(0, 1));
          cfg_plan[6] = 24'($urandom_range(0, 3));
        end
      endcase
      cfg_plan[0][23:16] = '0;
      for (int r = 0; r < 7; r++) write_reg(cfg_reg_t'(r), cfg_plan[r]);
      quiet = (ph == 3 || ph == 7);
      random_block(60);
      drain();
      random_block(63);
      drain();
      phases_run++;
    end

    $display("%0d frames sent, %0d checked, over %0d register settings",
             frames_sent, frames_checked, phases_run + 1);
    if (mismatches == 0 && pending_frames.size() == 0)
      $display("tb_sidechain_rms_compressor_core passed");
    else
      $display("tb_sidechain_rms_compressor_core failed");
    $finish;
  end

endmodule
`default_nettype wire
